// ===== rtl/twaa_pkg.sv =====
// twaa_pkg: types and constants shared by the touch wheel angle/amplitude block
// no dependencies; used by twaa_front, twaa_queue, twaa_back and the top level

package twaa_pkg;

  localparam logic [7:0] OFFSET_RESET = 8'h10;

  // sector bases of the wheel, in angle steps
  localparam logic [7:0] BASE_LO  = 8'd30;
  localparam logic [7:0] BASE_MID = 8'd90;
  localparam logic [7:0] BASE_HI  = 8'd150;

  localparam logic [7:0] ANGLE_MAX = 8'd180;

  // quotient (30 * lo) / hi is 0..30: five quotient bits, numerator below 2^13
  localparam int QBITS = 5;
  localparam int NUM_W = 13;

  // classified request handed from front to back
  typedef struct packed {
    logic [7:0] rem_lo;   // smaller remainder above the baseline
    logic [7:0] rem_hi;   // larger remainder, also the touch strength
    logic [7:0] base;     // sector base
    logic       sub;      // angle is base minus quotient
  } work_t;

  // one stage of the divider pipeline
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [7:0]       den;
    logic [QBITS-1:0] quo;
    logic [7:0]       base;
    logic             sub;
  } div_t;

endpackage

// ===== rtl/twaa_front.sv =====
// twaa_front: takes a sample triple, removes the offset, picks the baseline and sector
// depends on twaa_pkg (work_t, sector bases)

module twaa_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_sample_a,
  input  logic [7:0]        in_sample_b,
  input  logic [7:0]        in_sample_c,
  input  logic [7:0]        offset,
  input  logic              q_full,
  output logic              q_push,
  output twaa_pkg::work_t   q_data
);

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [7:0] rem_x;
  logic [7:0] rem_y;
  logic [1:0] baseline;

  localparam logic [1:0] BL_A = 2'd0;
  localparam logic [1:0] BL_B = 2'd1;
  localparam logic [1:0] BL_C = 2'd2;

  assign a = in_sample_a - offset;
  assign b = in_sample_b - offset;
  assign c = in_sample_c - offset;

  always_comb begin
    if (a < b && a < c) begin
      baseline = BL_A;
    end else if (b < c) begin
      baseline = BL_B;
    end else begin
      baseline = BL_C;
    end
  end

  // rem_x is the first of the two non-baseline electrodes in a, b, c order
  always_comb begin
    rem_x     = 8'd0;
    rem_y     = 8'd0;
    q_data    = '0;
    case (baseline)
      BL_A: begin
        rem_x = b - a;
        rem_y = c - a;
      end
      BL_B: begin
        rem_x = a - b;
        rem_y = c - b;
      end
      default: begin
        rem_x = a - c;
        rem_y = b - c;
      end
    endcase

    if (rem_x > rem_y) begin
      q_data.rem_hi = rem_x;
      q_data.rem_lo = rem_y;
    end else begin
      q_data.rem_hi = rem_y;
      q_data.rem_lo = rem_x;
    end

    case (baseline)
      BL_A: begin
        q_data.base = (rem_x > rem_y) ? twaa_pkg::BASE_LO : twaa_pkg::BASE_MID;
        q_data.sub  = !(rem_x > rem_y);
      end
      BL_B: begin
        q_data.base = (rem_x > rem_y) ? twaa_pkg::BASE_HI : twaa_pkg::BASE_MID;
        q_data.sub  = (rem_x > rem_y);
      end
      default: begin
        q_data.base = (rem_x > rem_y) ? twaa_pkg::BASE_HI : twaa_pkg::BASE_LO;
        q_data.sub  = !(rem_x > rem_y);
      end
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/twaa_queue.sv =====
// twaa_queue: short first-in first-out queue of classified requests
// depends on twaa_pkg (work_t)

module twaa_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  twaa_pkg::work_t   push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output twaa_pkg::work_t   pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  twaa_pkg::work_t entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/twaa_back.sv =====
// twaa_back: pipelined restoring divider, one quotient bit per stage, and result register
// depends on twaa_pkg (work_t, div_t, QBITS, NUM_W)

module twaa_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  twaa_pkg::work_t   q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_wheel_angle,
  output logic [7:0]        out_touch_strength
);

  localparam int QB = twaa_pkg::QBITS;
  localparam int NW = twaa_pkg::NUM_W;

  logic [QB:0]        v_r;
  twaa_pkg::div_t     st_r [QB+1];
  logic [QB+1:0]      rdy;
  logic               out_valid_r;
  logic [7:0]         angle_r;
  logic [7:0]         strength_r;
  twaa_pkg::div_t     load;
  logic [QB-1:0]      quo_eff;

  // a stage takes new data when empty or when its successor moves
  assign rdy[QB+1] = !out_valid_r || out_ready;
  for (genvar k = 0; k <= QB; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign q_pop = q_valid && rdy[0];

  // numerator 30 * lo as (lo << 5) - (lo << 1)
  always_comb begin
    load      = '0;
    load.rem  = (NW'(q_data.rem_lo) << 5) - (NW'(q_data.rem_lo) << 1);
    load.den  = q_data.rem_hi;
    load.base = q_data.base;
    load.sub  = q_data.sub;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st_r[0] <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= q_valid;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_stage
    localparam int SH = QB - j;
    logic [NW-1:0]  trial;
    logic           fits;
    twaa_pkg::div_t nxt;

    assign trial = NW'(st_r[j-1].den) << SH;
    assign fits  = (st_r[j-1].rem >= trial);

    always_comb begin
      nxt     = st_r[j-1];
      nxt.rem = fits ? st_r[j-1].rem - trial : st_r[j-1].rem;
      nxt.quo = {st_r[j-1].quo[QB-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        st_r[j] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  // zero divisor means all three samples matched: quotient forced to zero
  assign quo_eff = (st_r[QB].den == 8'd0) ? '0 : st_r[QB].quo;

  always_ff @(posedge clk) begin
    if (rdy[QB+1]) begin
      angle_r    <= st_r[QB].sub ? st_r[QB].base - 8'(quo_eff)
                                 : st_r[QB].base + 8'(quo_eff);
      strength_r <= st_r[QB].den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[QB+1]) begin
      out_valid_r <= v_r[QB];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_wheel_angle    = angle_r;
  assign out_touch_strength = strength_r;

endmodule

// ===== rtl/touch_wheel_angle_amplitude.sv =====
// touch_wheel_angle_amplitude: top level of the three-electrode wheel position block
// depends on twaa_pkg, twaa_front, twaa_queue, twaa_back
//
// Usage:
//   Input channel in_valid/in_ready carries three raw charge-time samples
//   (in_sample_a/b/c). Result channel out_valid/out_ready carries the wheel
//   angle (0..180) and the touch strength. One result per request, in order.
//   cfg_valid/cfg_ready writes cfg_sample_offset, the value removed from every
//   sample; cfg_ready is always high. Write it only while the block is idle.
// Path: the front classifies in the accept cycle, then the request passes
//   through the queue register, a load stage, five divider stages (one
//   quotient bit each) and the result register.
// Throughput: one request per cycle while out_ready stays high, set by the fully pipelined divider.
// Stall: when out_ready is low the pipeline fills, then the queue fills
//   (QUEUE_DEPTH entries) and in_ready drops; nothing is dropped.
// Reset: queue and pipeline empty, out_valid low, sample offset 16.

module touch_wheel_angle_amplitude #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_sample_a,
  input  logic [7:0] in_sample_b,
  input  logic [7:0] in_sample_c,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_wheel_angle,
  output logic [7:0] out_touch_strength,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_sample_offset
);

  logic            cfg_write;
  logic [7:0]      sample_offset_r;
  logic            q_full;
  logic            q_push;
  twaa_pkg::work_t q_wdata;
  logic            q_pop;
  logic            q_valid;
  twaa_pkg::work_t q_rdata;

  assign cfg_write = cfg_valid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_offset_r <= twaa_pkg::OFFSET_RESET;
    end else if (cfg_write && cfg_ready) begin
      sample_offset_r <= cfg_sample_offset;
    end
  end

  twaa_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample_a (in_sample_a),
    .in_sample_b (in_sample_b),
    .in_sample_c (in_sample_c),
    .offset      (sample_offset_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  twaa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  twaa_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_wheel_angle    (out_wheel_angle),
    .out_touch_strength (out_touch_strength)
  );

endmodule

// ===== rtl/twaa_checker.sv =====
// twaa_checker: port-level assertions for touch_wheel_angle_amplitude
// depends on nothing; bound to the top level at the end of this file

module twaa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_wheel_angle,
  input logic [7:0] out_touch_strength
);

  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam logic [7:0] ANGLE_FLAT = 8'd30;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wheel_angle)
      && $stable(out_touch_strength))
    else $error("result changed while stalled");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_wheel_angle <= ANGLE_MAX)
    else $error("wheel angle above 180");

  // no touch means all samples equal, which lands on the flat sector
  a_flat_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_touch_strength == 8'd0 |-> out_wheel_angle == ANGLE_FLAT)
    else $error("zero strength with angle other than 30");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind touch_wheel_angle_amplitude twaa_checker u_twaa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_wheel_angle    (out_wheel_angle),
  .out_touch_strength (out_touch_strength)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// testbench: random and directed check of touch_wheel_angle_amplitude against its own predictor
// depends only on the top level rtl/touch_wheel_angle_amplitude.sv and what it pulls in

module testbench;

  localparam logic [7:0] OFFSET_AT_RESET = 8'd16;
  localparam int         SECTOR_STEP     = 30;
  localparam logic [7:0] SECTOR_LO       = 8'd30;
  localparam logic [7:0] SECTOR_MID      = 8'd90;
  localparam logic [7:0] SECTOR_HI       = 8'd150;
  localparam int         PIPE_LATENCY    = 7;
  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         PHASES          = 6;
  localparam int         ITEMS_PER_PHASE = 280;
  localparam int         PRINT_CAP       = 40;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } sample_triple_t;

  typedef struct packed {
    logic [7:0] angle;
    logic [7:0] strength;
  } wheel_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_sample_a = 8'd0;
  logic [7:0] in_sample_b = 8'd0;
  logic [7:0] in_sample_c = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_wheel_angle;
  logic [7:0] out_touch_strength;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_sample_offset = 8'd0;

  sample_triple_t sample_queue[$];
  wheel_result_t  expected_positions[$];
  logic [7:0]     offset_setting = OFFSET_AT_RESET;
  bit             jitter_on = 1'b1;
  int unsigned    idle_odds = 4;
  int unsigned    send_gap = 0;
  int unsigned    recv_stall = 0;
  int unsigned    fail_count = 0;
  int unsigned    result_count = 0;
  int unsigned    cycle_count = 0;

  touch_wheel_angle_amplitude u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .in_sample_c       (in_sample_c),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_wheel_angle   (out_wheel_angle),
    .out_touch_strength(out_touch_strength),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sample_offset (cfg_sample_offset)
  );

  always #1 clk = ~clk;

  // angle and strength for one raw triple under the given offset
  function automatic wheel_result_t wheel_position(input sample_triple_t raw,
                                                   input logic [7:0] offset);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] base;
    logic       sub;
    int         q;
    wheel_result_t r;
    a = raw.a - offset;
    b = raw.b - offset;
    c = raw.c - offset;
    if (a < b && a < c) begin
      d1 = b - a;
      d2 = c - a;
      if (d1 > d2) begin
        hi = d1; lo = d2; base = SECTOR_LO; sub = 1'b0;
      end else begin
        hi = d2; lo = d1; base = SECTOR_MID; sub = 1'b1;
      end
    end else if (b < c) begin
      d1 = a - b;
      d2 = c - b;
      if (d1 > d2) begin
        hi = d1; lo = d2; base = SECTOR_HI; sub = 1'b1;
      end else begin
        hi = d2; lo = d1; base = SECTOR_MID; sub = 1'b0;
      end
    end else begin
      d1 = a - c;
      d2 = b - c;
      if (d1 > d2) begin
        hi = d1; lo = d2; base = SECTOR_HI; sub = 1'b0;
      end else begin
        hi = d2; lo = d1; base = SECTOR_LO; sub = 1'b1;
      end
    end
    // all three equal: zero over zero is taken as zero
    q = (hi == 8'd0) ? 0 : (SECTOR_STEP * int'(lo)) / int'(hi);
    r.angle = sub ? base - 8'(q) : base + 8'(q);
    r.strength = hi;
    return r;
  endfunction

  // random triple, shaped in the offset-corrected domain to hit ties, near-ties and extremes
  function automatic sample_triple_t random_triple(input logic [7:0] offset);
    logic [7:0]     v [3];
    logic [7:0]     pivot;
    int unsigned    kind;
    int unsigned    k;
    sample_triple_t t;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) v[i] = 8'($urandom);
    pivot = 8'($urandom);
    case (kind)
      6: begin
        v[0] = pivot; v[1] = pivot; v[2] = pivot;
      end
      7: begin
        k = $urandom_range(0, 2);
        v[k] = pivot;
        v[(k + 1) % 3] = pivot;
      end
      8: begin
        for (int i = 0; i < 3; i++) v[i] = pivot + 8'($urandom_range(0, 3));
      end
      9: begin
        k = $urandom_range(0, 2);
        v[k] = 8'd0;
        v[(k + 1 + $urandom_range(0, 1)) % 3] = 8'd255;
      end
      default: ;
    endcase
    t.a = v[0] + offset;
    t.b = v[1] + offset;
    t.c = v[2] + offset;
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_positions.size() != 0);
  endtask

  task automatic write_offset(input logic [7:0] value);
    cfg_sample_offset <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    offset_setting = value;
  endtask

  // driver: holds each request until accepted, idles in bursts
  always @(posedge clk) begin
    bit             busy;
    sample_triple_t held;
    sample_triple_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        held = '{in_sample_a, in_sample_b, in_sample_c};
        expected_positions.push_back(wheel_position(held, offset_setting));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (jitter_on && $urandom_range(0, idle_odds) == 0) begin
          send_gap = $urandom_range(1, 5) - 1;
          in_valid <= 1'b0;
        end else begin
          nxt = sample_queue.pop_front();
          in_valid <= 1'b1;
          in_sample_a <= nxt.a;
          in_sample_b <= nxt.b;
          in_sample_c <= nxt.c;
        end
      end
    end
  end

  // monitor: compares each result with the oldest prediction
  always @(posedge clk) begin
    wheel_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending: angle %0d strength %0d",
                                    result_count, out_wheel_angle, out_touch_strength));
        end else begin
          want = expected_positions.pop_front();
          if (out_wheel_angle !== want.angle)
            report_mismatch($sformatf("result %0d wheel_angle got %0d want %0d",
                                      result_count, out_wheel_angle, want.angle));
          if (out_touch_strength !== want.strength)
            report_mismatch($sformatf("result %0d touch_strength got %0d want %0d",
                                      result_count, out_touch_strength, want.strength));
        end
        result_count++;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, idle_odds) == 0) begin
        recv_stall = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_positions.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] offset_plan [PHASES];
    offset_plan[0] = 8'd0;
    offset_plan[1] = 8'd255;
    offset_plan[2] = 8'd1;
    offset_plan[3] = 8'($urandom);
    offset_plan[4] = 8'd128;
    offset_plan[5] = 8'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, under the reset offset of 16: each sector, ties, wrap, extremes
    sample_queue.push_back(sample_triple_t'{8'd16, 8'd200, 8'd100});
    sample_queue.push_back(sample_triple_t'{8'd16, 8'd100, 8'd200});
    sample_queue.push_back(sample_triple_t'{8'd200, 8'd16, 8'd100});
    sample_queue.push_back(sample_triple_t'{8'd100, 8'd16, 8'd200});
    sample_queue.push_back(sample_triple_t'{8'd200, 8'd100, 8'd16});
    sample_queue.push_back(sample_triple_t'{8'd100, 8'd200, 8'd16});
    sample_queue.push_back(sample_triple_t'{8'd16, 8'd16, 8'd16});
    sample_queue.push_back(sample_triple_t'{8'd0, 8'd0, 8'd0});
    sample_queue.push_back(sample_triple_t'{8'd255, 8'd255, 8'd255});
    sample_queue.push_back(sample_triple_t'{8'd50, 8'd50, 8'd80});
    sample_queue.push_back(sample_triple_t'{8'd80, 8'd50, 8'd50});
    sample_queue.push_back(sample_triple_t'{8'd50, 8'd80, 8'd50});
    sample_queue.push_back(sample_triple_t'{8'd90, 8'd90, 8'd10});
    sample_queue.push_back(sample_triple_t'{8'd10, 8'd90, 8'd90});
    sample_queue.push_back(sample_triple_t'{8'd90, 8'd10, 8'd90});
    sample_queue.push_back(sample_triple_t'{8'd0, 8'd255, 8'd15});
    sample_queue.push_back(sample_triple_t'{8'd16, 8'd15, 8'd100});
    sample_queue.push_back(sample_triple_t'{8'd0, 8'd255, 8'd0});
    sample_queue.push_back(sample_triple_t'{8'd255, 8'd0, 8'd255});
    sample_queue.push_back(sample_triple_t'{8'd0, 8'd0, 8'd255});
    sample_queue.push_back(sample_triple_t'{8'd255, 8'd255, 8'd0});
    sample_queue.push_back(sample_triple_t'{8'd16, 8'd17, 8'd16});
    sample_queue.push_back(sample_triple_t'{8'd15, 8'd16, 8'd17});

    for (int p = 0; p < PHASES; p++) begin
      // sender holds off until the pipeline has fully drained
      wait_idle();
      write_offset(offset_plan[p]);
      idle_odds = (p % 2 == 0) ? 3 : 12;
      if (p == PHASES - 1) jitter_on = 1'b0;
      repeat (ITEMS_PER_PHASE) sample_queue.push_back(random_triple(offset_plan[p]));
    end

    wait_idle();
    repeat (PIPE_LATENCY + 3) @(posedge clk);
    if (fail_count == 0 && expected_positions.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/twaa_pkg.sv
rtl/twaa_front.sv
rtl/twaa_queue.sv
rtl/twaa_back.sv
rtl/touch_wheel_angle_amplitude.sv
rtl/twaa_checker.sv
dv/testbench.sv
